// ===== rtl/tbjse_pkg.sv =====
package tbjse_pkg;

    // Default bound of the container stack.
    localparam int DEF_STACK_DEPTH = 16;

    // Request codes carried in req_type.
    typedef enum logic [3:0] {
        REQ_START  = 4'd0,
        REQ_NULL   = 4'd1,
        REQ_BOOL   = 4'd2,
        REQ_INT    = 4'd3,
        REQ_STRING = 4'd4,
        REQ_KEY    = 4'd5,
        REQ_TEXT   = 4'd6,
        REQ_OBJECT = 4'd7,
        REQ_ARRAY  = 4'd8,
        REQ_POP    = 4'd9,
        REQ_UUID   = 4'd10,
        REQ_TIME   = 4'd11,
        REQ_FINISH = 4'd12
    } req_code_t;

    // Status codes carried in each result.
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_TOO_DEEP    = 2'd1,
        ST_NOTHING_POP = 2'd2,
        ST_KEY_OUTSIDE = 2'd3
    } status_code_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_HEAD  = 2'd1,
        S_DATA  = 2'd2,
        S_CLOSE = 2'd3
    } seq_state_t;

    // Tag bytes of the encoding.
    localparam logic [7:0] TAG_NULL  = 8'h5A; // Z
    localparam logic [7:0] TAG_TRUE  = 8'h74; // t
    localparam logic [7:0] TAG_FALSE = 8'h66; // f
    localparam logic [7:0] TAG_INT1  = 8'h69; // i
    localparam logic [7:0] TAG_INT2  = 8'h6A; // j
    localparam logic [7:0] TAG_INT4  = 8'h6B; // k
    localparam logic [7:0] TAG_INT8  = 8'h49; // I
    localparam logic [7:0] TAG_STR1  = 8'h73; // s
    localparam logic [7:0] TAG_STR2  = 8'h53; // S
    localparam logic [7:0] TAG_STR4  = 8'h42; // B
    localparam logic [7:0] TAG_UUID  = 8'h75; // u
    localparam logic [7:0] TAG_TIME  = 8'h54; // T
    localparam logic [7:0] TAG_OBEG  = 8'h7B; // {
    localparam logic [7:0] TAG_OEND  = 8'h7D; // }
    localparam logic [7:0] TAG_ABEG  = 8'h5B; // [
    localparam logic [7:0] TAG_AEND  = 8'h5D; // ]

    // One input token.
    typedef struct packed {
        logic [3:0]         req_type;
        logic signed [63:0] value;
        logic [63:0]        value_low;
        logic               flag_value;
        logic [31:0]        text_len;
        logic [7:0]         text_byte;
    } token_t;

    // One result item.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        last;
        logic [1:0]  status;
        logic [31:0] body_length;
    } result_t;

    // Stack operations requested by the sequencer.
    typedef struct packed {
        logic push;
        logic push_kind;
        logic pop;
        logic clear;
    } stk_cmd_t;

    // Stack condition seen by the sequencer.
    typedef struct packed {
        logic empty;
        logic full;
        logic one;
        logic top_kind;
    } stk_stat_t;

endpackage

// ===== rtl/tbjse_stack.sv =====
module tbjse_stack #(
    parameter int STACK_DEPTH = tbjse_pkg::DEF_STACK_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tbjse_pkg::stk_cmd_t  cmd,
    output tbjse_pkg::stk_stat_t stat
);
    import tbjse_pkg::*;

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [STACK_DEPTH-1:0] kind_reg;
    logic [DW-1:0]          depth_reg;
    logic [DW-1:0]          depth_next;
    logic [DW-1:0]          top_pos;
    logic [IW-1:0]          top_idx;
    logic [IW-1:0]          push_idx;

    assign top_pos  = depth_reg - DW'(1);
    assign top_idx  = top_pos[IW-1:0];
    assign push_idx = depth_reg[IW-1:0];

    // Condition flags for the sequencer; an empty stack reports an array on top.
    always_comb
    begin
        stat.empty    = (depth_reg == '0);
        stat.full     = (depth_reg == DW'(STACK_DEPTH));
        stat.one      = (depth_reg == DW'(1));
        stat.top_kind = (depth_reg != '0) && kind_reg[top_idx];
    end

    // Depth update: clear wins, then push or pop.
    always_comb
    begin
        depth_next = depth_reg;
        if (cmd.clear)
        begin
            depth_next = '0;
        end
        else if (cmd.push)
        begin
            depth_next = depth_reg + DW'(1);
        end
        else if (cmd.pop)
        begin
            depth_next = top_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    // Container kinds, one bit per level: 1 object, 0 array.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg <= '0;
        end
        else if (cmd.push && !cmd.clear)
        begin
            kind_reg[push_idx] <= cmd.push_kind;
        end
    end

endmodule

// ===== rtl/tbjse_seq.sv =====
module tbjse_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 token_valid,
    output logic                 token_ready,
    input  tbjse_pkg::token_t    token,
    output logic                 result_valid,
    input  logic                 result_ready,
    output tbjse_pkg::result_t   result,
    output tbjse_pkg::stk_cmd_t  stk_cmd,
    input  tbjse_pkg::stk_stat_t stk_stat
);
    import tbjse_pkg::*;

    seq_state_t   state_reg, state_next;
    logic [7:0]   head_byte_reg, head_byte_next;
    logic         head_valid_reg, head_valid_next;
    logic [1:0]   head_status_reg, head_status_next;
    logic [4:0]   cnt_reg, cnt_next;
    logic [127:0] shift_reg, shift_next;
    logic [31:0]  count_reg, count_next;
    result_t      res_reg, res_next;
    logic         res_valid_reg, res_valid_next;

    logic         accept;
    logic         out_free;
    logic         int_fits1, int_fits2, int_fits4;
    logic         len_fits1, len_fits2;
    logic [7:0]   int_tag, len_tag;
    logic [4:0]   int_cnt, len_cnt;
    logic [127:0] int_shift, len_shift;
    logic [31:0]  count_inc;

    assign token_ready  = (state_reg == S_IDLE);
    assign accept       = token_valid && token_ready;
    assign out_free     = !res_valid_reg || result_ready;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign count_inc    = count_reg + 32'd1;

    // Integer size pick: the upper bits must all copy the sign bit.
    assign int_fits1 = (&token.value[63:7])  || !(|token.value[63:7]);
    assign int_fits2 = (&token.value[63:15]) || !(|token.value[63:15]);
    assign int_fits4 = (&token.value[63:31]) || !(|token.value[63:31]);

    always_comb
    begin
        if (int_fits1)
        begin
            int_tag   = TAG_INT1;
            int_cnt   = 5'd1;
            int_shift = {token.value[7:0], 120'h0};
        end
        else if (int_fits2)
        begin
            int_tag   = TAG_INT2;
            int_cnt   = 5'd2;
            int_shift = {token.value[15:0], 112'h0};
        end
        else if (int_fits4)
        begin
            int_tag   = TAG_INT4;
            int_cnt   = 5'd4;
            int_shift = {token.value[31:0], 96'h0};
        end
        else
        begin
            int_tag   = TAG_INT8;
            int_cnt   = 5'd8;
            int_shift = {token.value, 64'h0};
        end
    end

    // Length form pick for string and key headers.
    assign len_fits1 = !(|token.text_len[31:7]);
    assign len_fits2 = !(|token.text_len[31:15]);

    always_comb
    begin
        if (len_fits1)
        begin
            len_tag   = TAG_STR1;
            len_cnt   = 5'd1;
            len_shift = {token.text_len[7:0], 120'h0};
        end
        else if (len_fits2)
        begin
            len_tag   = TAG_STR2;
            len_cnt   = 5'd2;
            len_shift = {token.text_len[15:0], 112'h0};
        end
        else
        begin
            len_tag   = TAG_STR4;
            len_cnt   = 5'd4;
            len_shift = {token.text_len, 96'h0};
        end
    end

    // Next state, decode of an accepted request, and result generation.
    always_comb
    begin
        state_next       = state_reg;
        head_byte_next   = head_byte_reg;
        head_valid_next  = head_valid_reg;
        head_status_next = head_status_reg;
        cnt_next         = cnt_reg;
        shift_next       = shift_reg;
        count_next       = count_reg;
        res_next         = res_reg;
        res_valid_next   = res_valid_reg && !result_ready;
        stk_cmd          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // By default a request gives a single byte with an ok status.
                    head_byte_next   = 8'h00;
                    head_valid_next  = 1'b1;
                    head_status_next = ST_OK;
                    cnt_next         = 5'd0;
                    state_next       = S_HEAD;
                    case (req_code_t'(token.req_type))
                        REQ_START:
                        begin
                            head_valid_next = 1'b0;
                            stk_cmd.clear   = 1'b1;
                            count_next      = 32'd0;
                        end
                        REQ_NULL:
                        begin
                            head_byte_next = TAG_NULL;
                        end
                        REQ_BOOL:
                        begin
                            head_byte_next = token.flag_value ? TAG_TRUE : TAG_FALSE;
                        end
                        REQ_INT:
                        begin
                            head_byte_next = int_tag;
                            cnt_next       = int_cnt;
                            shift_next     = int_shift;
                        end
                        REQ_STRING:
                        begin
                            head_byte_next = len_tag;
                            cnt_next       = len_cnt;
                            shift_next     = len_shift;
                        end
                        REQ_KEY:
                        begin
                            if (!stk_stat.top_kind)
                            begin
                                head_valid_next  = 1'b0;
                                head_status_next = ST_KEY_OUTSIDE;
                            end
                            else
                            begin
                                head_byte_next = len_tag;
                                cnt_next       = len_cnt;
                                shift_next     = len_shift;
                            end
                        end
                        REQ_TEXT:
                        begin
                            head_byte_next = token.text_byte;
                        end
                        REQ_OBJECT, REQ_ARRAY:
                        begin
                            if (stk_stat.full)
                            begin
                                head_valid_next  = 1'b0;
                                head_status_next = ST_TOO_DEEP;
                            end
                            else
                            begin
                                stk_cmd.push      = 1'b1;
                                stk_cmd.push_kind = (token.req_type == REQ_OBJECT);
                                head_byte_next    = (token.req_type == REQ_OBJECT) ?
                                                    TAG_OBEG : TAG_ABEG;
                            end
                        end
                        REQ_POP:
                        begin
                            if (stk_stat.empty)
                            begin
                                head_valid_next  = 1'b0;
                                head_status_next = ST_NOTHING_POP;
                            end
                            else
                            begin
                                stk_cmd.pop    = 1'b1;
                                head_byte_next = stk_stat.top_kind ? TAG_OEND : TAG_AEND;
                            end
                        end
                        REQ_UUID:
                        begin
                            head_byte_next = TAG_UUID;
                            cnt_next       = 5'd16;
                            shift_next     = {token.value, token.value_low};
                        end
                        REQ_TIME:
                        begin
                            head_byte_next = TAG_TIME;
                            cnt_next       = 5'd8;
                            shift_next     = {token.value, 64'h0};
                        end
                        REQ_FINISH:
                        begin
                            if (stk_stat.empty)
                            begin
                                head_valid_next = 1'b0;
                            end
                            else
                            begin
                                state_next = S_CLOSE;
                            end
                        end
                        default:
                        begin
                            head_valid_next = 1'b0;
                        end
                    endcase
                end
            end

            S_HEAD:
            begin
                // First result: a tag or content byte, or status alone.
                if (out_free)
                begin
                    res_valid_next       = 1'b1;
                    res_next.out_byte    = head_valid_reg ? head_byte_reg : 8'h00;
                    res_next.byte_valid  = head_valid_reg;
                    res_next.last        = (cnt_reg == 5'd0);
                    res_next.status      = head_status_reg;
                    res_next.body_length = head_valid_reg ? count_inc : count_reg;
                    if (head_valid_reg)
                    begin
                        count_next = count_inc;
                    end
                    state_next = (cnt_reg == 5'd0) ? S_IDLE : S_DATA;
                end
            end

            S_DATA:
            begin
                // Big-endian payload, one byte off the top of the shift register.
                if (out_free)
                begin
                    res_valid_next       = 1'b1;
                    res_next.out_byte    = shift_reg[127:120];
                    res_next.byte_valid  = 1'b1;
                    res_next.last        = (cnt_reg == 5'd1);
                    res_next.status      = ST_OK;
                    res_next.body_length = count_inc;
                    count_next           = count_inc;
                    shift_next           = {shift_reg[119:0], 8'h00};
                    cnt_next             = cnt_reg - 5'd1;
                    if (cnt_reg == 5'd1)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_CLOSE:
            begin
                // Finish: close the innermost open level each step.
                if (out_free)
                begin
                    stk_cmd.pop          = 1'b1;
                    res_valid_next       = 1'b1;
                    res_next.out_byte    = stk_stat.top_kind ? TAG_OEND : TAG_AEND;
                    res_next.byte_valid  = 1'b1;
                    res_next.last        = stk_stat.one;
                    res_next.status      = ST_OK;
                    res_next.body_length = count_inc;
                    count_next           = count_inc;
                    if (stk_stat.one)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            count_reg     <= 32'd0;
            cnt_reg       <= 5'd0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            count_reg     <= count_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        head_byte_reg   <= head_byte_next;
        head_valid_reg  <= head_valid_next;
        head_status_reg <= head_status_next;
        shift_reg       <= shift_next;
        res_reg         <= res_next;
    end

endmodule

// ===== rtl/tagged_binary_json_stream_encoder_top.sv =====
// An accepted request is registered and moves to S_HEAD, or S_CLOSE for a finish with open
// levels; its first result is then registered in the output register once it is free. A
// request gives N results (N is 1 to 17, up to STACK_DEPTH for finish), one per cycle unless
// stalled. token_ready returns once the last result of a request sits in the output register.
// Reset (rst_n low, asynchronous) empties the container stack and zeroes the byte count.
module tagged_binary_json_stream_encoder_top #(
    parameter int STACK_DEPTH = tbjse_pkg::DEF_STACK_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               token_valid,
    output logic               token_ready,
    input  tbjse_pkg::token_t  token,
    output logic               result_valid,
    input  logic               result_ready,
    output tbjse_pkg::result_t result
);
    import tbjse_pkg::*;

    stk_cmd_t  stk_cmd;
    stk_stat_t stk_stat;

    // Byte sequencer with the shared shift register.
    tbjse_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .token_valid  (token_valid),
        .token_ready  (token_ready),
        .token        (token),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .stk_cmd      (stk_cmd),
        .stk_stat     (stk_stat)
    );

    // Stack of open containers.
    tbjse_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (stk_cmd),
        .stat  (stk_stat)
    );

    // The stack is never pushed past its bound.
    assert property (@(posedge clk) disable iff (!rst_n)
        stk_cmd.push |-> !stk_stat.full)
    else $error("stack push while full");

    // The stack is never popped when empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        stk_cmd.pop |-> !stk_stat.empty)
    else $error("stack pop while empty");

    // A request is never accepted back to back: acceptance takes token_ready low.
    assert property (@(posedge clk) disable iff (!rst_n)
        (token_valid && token_ready) |=> !token_ready)
    else $error("request accepted back to back");

    // A result that carries a byte always reports ok status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.byte_valid) |-> (result.status == ST_OK))
    else $error("byte result with error status");

endmodule

// ===== tb/tbjse_stream_check.sv =====
`timescale 1ns / 1ps

// Watches both channels of the encoder. It predicts the bytes and status of
// every accepted request, and it compares each accepted result with the oldest
// prediction that is still waiting.
module tbjse_stream_check #(
    parameter int STACK_DEPTH = tbjse_pkg::DEF_STACK_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                token_valid,
    input  logic                token_ready,
    input  tbjse_pkg::token_t   token,
    input  logic                result_valid,
    input  logic                result_ready,
    input  tbjse_pkg::result_t  result,
    output int                  error_count,
    output int                  pending,
    output int                  checked
);

    import tbjse_pkg::*;

    // This is the predicted state of the encoder.
    logic        open_kind [STACK_DEPTH];
    int          open_levels;
    logic [31:0] byte_count;

    // These hold the results of the current request and the results still due.
    result_t     request_bytes [$];
    result_t     expected_bytes [$];
    int          err_cnt;
    int          check_cnt;

    // Emits one data byte and advances the body length.
    function automatic void emit_byte(logic [7:0] b);
        result_t r;
        byte_count = byte_count + 32'd1;
        r = '0;
        r.out_byte = b;
        r.byte_valid = 1'b1;
        r.body_length = byte_count;
        request_bytes.push_back(r);
    endfunction

    // Emits a result that carries only a status.
    function automatic void emit_status(status_code_t st);
        result_t r;
        r = '0;
        r.status = st;
        r.body_length = byte_count;
        request_bytes.push_back(r);
    endfunction

    // Emits the low nbytes bytes of v, most significant first.
    function automatic void emit_be(logic [63:0] v, int nbytes);
        for (int i = nbytes - 1; i >= 0; i--)
            emit_byte(v[8*i +: 8]);
    endfunction

    // Emits a string or key length in the shortest of its three forms.
    function automatic void emit_length(logic [31:0] len);
        if (len <= 32'd127)
        begin
            emit_byte(TAG_STR1);
            emit_be(64'(len), 1);
        end
        else if (len <= 32'd32767)
        begin
            emit_byte(TAG_STR2);
            emit_be(64'(len), 2);
        end
        else
        begin
            emit_byte(TAG_STR4);
            emit_be(64'(len), 4);
        end
    endfunction

    // Emits an integer in the shortest two's complement form that holds it.
    function automatic void emit_int(logic [63:0] u);
        if (u + 64'h80 < 64'h100)
        begin
            emit_byte(TAG_INT1);
            emit_be(u, 1);
        end
        else if (u + 64'h8000 < 64'h1_0000)
        begin
            emit_byte(TAG_INT2);
            emit_be(u, 2);
        end
        else if (u + 64'h8000_0000 < 64'h1_0000_0000)
        begin
            emit_byte(TAG_INT4);
            emit_be(u, 4);
        end
        else
        begin
            emit_byte(TAG_INT8);
            emit_be(u, 8);
        end
    endfunction

    // Opens an object (kind 1) or an array (kind 0) unless the stack is full.
    function automatic void open_level(logic kind);
        if (open_levels >= STACK_DEPTH)
        begin
            emit_status(ST_TOO_DEEP);
        end
        else
        begin
            open_kind[open_levels] = kind;
            open_levels++;
            emit_byte(kind ? TAG_OBEG : TAG_ABEG);
        end
    endfunction

    // Closes the innermost open level.
    function automatic void close_level();
        open_levels--;
        emit_byte(open_kind[open_levels] ? TAG_OEND : TAG_AEND);
    endfunction

    // Works out every result of one request and queues them in order.
    function automatic void encode_token(token_t t);
        result_t tail;
        request_bytes.delete();
        case (t.req_type)
            REQ_START:
            begin
                open_levels = 0;
                byte_count = '0;
                emit_status(ST_OK);
            end
            REQ_NULL:   emit_byte(TAG_NULL);
            REQ_BOOL:   emit_byte(t.flag_value ? TAG_TRUE : TAG_FALSE);
            REQ_INT:    emit_int(t.value);
            REQ_STRING: emit_length(t.text_len);
            REQ_KEY:
            begin
                if (open_levels == 0 || !open_kind[open_levels - 1])
                    emit_status(ST_KEY_OUTSIDE);
                else
                    emit_length(t.text_len);
            end
            REQ_TEXT:   emit_byte(t.text_byte);
            REQ_OBJECT: open_level(1'b1);
            REQ_ARRAY:  open_level(1'b0);
            REQ_POP:
            begin
                if (open_levels == 0)
                    emit_status(ST_NOTHING_POP);
                else
                    close_level();
            end
            REQ_UUID:
            begin
                emit_byte(TAG_UUID);
                emit_be(t.value, 8);
                emit_be(t.value_low, 8);
            end
            REQ_TIME:
            begin
                emit_byte(TAG_TIME);
                emit_be(t.value, 8);
            end
            REQ_FINISH:
            begin
                while (open_levels > 0)
                    close_level();
                if (request_bytes.size() == 0)
                    emit_status(ST_OK);
            end
            default:    emit_status(ST_OK);
        endcase

        // The final result of the request carries the last mark.
        tail = request_bytes[request_bytes.size() - 1];
        tail.last = 1'b1;
        request_bytes[request_bytes.size() - 1] = tail;
        foreach (request_bytes[i])
            expected_bytes.push_back(request_bytes[i]);
    endfunction

    // Reports one field that differs and returns 1 if it does.
    function automatic int field_differs(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Both channels are sampled at the rising edge, before the edge's updates land.
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        int      bad;
        if (!rst_n)
        begin
            for (int i = 0; i < STACK_DEPTH; i++)
                open_kind[i] = 1'b0;
            open_levels = 0;
            byte_count = '0;
            expected_bytes.delete();
            err_cnt = 0;
            check_cnt = 0;
            error_count <= 0;
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            if (token_valid && token_ready)
                encode_token(token);

            if (result_valid && result_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual 0x%0h",
                             $time, result);
                    err_cnt++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    bad = field_differs("out_byte", 64'(want.out_byte), 64'(result.out_byte))
                        + field_differs("byte_valid", 64'(want.byte_valid),
                                        64'(result.byte_valid))
                        + field_differs("last", 64'(want.last), 64'(result.last))
                        + field_differs("status", 64'(want.status), 64'(result.status))
                        + field_differs("body_length", 64'(want.body_length),
                                        64'(result.body_length));
                    if (bad != 0)
                        err_cnt++;
                    check_cnt++;
                end
            end

            error_count <= err_cnt;
            pending <= expected_bytes.size();
            checked <= check_cnt;
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import tbjse_pkg::*;

    localparam int STACK_DEPTH     = DEF_STACK_DEPTH;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int RANDOM_REQUESTS = 45;

    logic    clk;
    logic    rst_n;
    logic    token_valid;
    logic    token_ready;
    token_t  token;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    int      error_count;
    int      pending;
    int      checked;

    // These variables shape the stimulus; they take no part in the checking.
    bit      idling;
    int      stall_left;
    int      cycles;
    int      requests_sent;
    int      sent_by_code [16];
    int      shadow_depth;
    logic    shadow_kind [STACK_DEPTH];
    int      deepest;

    tagged_binary_json_stream_encoder_top #(
        .STACK_DEPTH (STACK_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .token_valid  (token_valid),
        .token_ready  (token_ready),
        .token        (token),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    tbjse_stream_check #(
        .STACK_DEPTH (STACK_DEPTH)
    ) stream_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .token_valid  (token_valid),
        .token_ready  (token_ready),
        .token        (token),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .error_count  (error_count),
        .pending      (pending),
        .checked      (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The result side drops result_ready in bursts of random length, which begin only while idling is on.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            result_ready <= 1'b0;
        end
        else if (idling && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(1, 6) - 1;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    // A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.", cycles, pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // Signed value of random magnitude, so that all four integer forms show up.
    function automatic logic [63:0] rnd_int();
        logic signed [63:0] s;
        s = rnd64();
        return s >>> $urandom_range(0, 63);
    endfunction

    // Half are short lengths whose bytes follow; the rest lie near 127 or are random ones of any size.
    function automatic logic [31:0] rnd_len();
        case ($urandom_range(0, 3))
            0, 1:    return $urandom_range(0, 6);
            2:       return $urandom_range(120, 135);
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    // Presents one request, holds it until it is accepted, and returns at that edge.
    task automatic send_req(input logic [3:0] code, input logic [63:0] v,
                            input logic [63:0] vl, input logic f,
                            input logic [31:0] len, input logic [7:0] b);
        token_t t;
        t.req_type   = code;
        t.value      = v;
        t.value_low  = vl;
        t.flag_value = f;
        t.text_len   = len;
        t.text_byte  = b;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            token_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        token_valid <= 1'b1;
        token <= t;
        do
            @(posedge clk);
        while (!token_ready);

        requests_sent++;
        sent_by_code[code]++;
        case (code)
            REQ_START, REQ_FINISH: shadow_depth = 0;
            REQ_OBJECT, REQ_ARRAY:
            begin
                if (shadow_depth < STACK_DEPTH)
                begin
                    shadow_kind[shadow_depth] = (code == REQ_OBJECT);
                    shadow_depth++;
                end
            end
            REQ_POP: if (shadow_depth > 0) shadow_depth--;
            default: ;
        endcase
        if (shadow_depth > deepest)
            deepest = shadow_depth;
    endtask

    // Sends a request whose fields are all random apart from its code.
    task automatic send_op(input logic [3:0] code);
        send_req(code, rnd64(), rnd64(), 1'($urandom_range(0, 1)), $urandom,
                 8'($urandom_range(0, 255)));
    endtask

    // Sends a string or key header, followed by its bytes when the length is short.
    task automatic send_text(input logic [3:0] code, input logic [31:0] len);
        send_req(code, rnd64(), rnd64(), 1'($urandom_range(0, 1)), len,
                 8'($urandom_range(0, 255)));
        if (len <= 32'd8)
            repeat (len) send_op(REQ_TEXT);
    endtask

    // Sends one value: a scalar, or the opening of a container.
    task automatic send_value();
        case ($urandom_range(0, 9))
            0:       send_op(REQ_NULL);
            1:       send_op(REQ_BOOL);
            2, 3:    send_req(REQ_INT, rnd_int(), rnd64(), 1'($urandom_range(0, 1)), $urandom,
                              8'($urandom_range(0, 255)));
            4, 5:    send_text(REQ_STRING, rnd_len());
            6:       send_op(REQ_UUID);
            7:       send_op(REQ_TIME);
            8:       send_op(REQ_OBJECT);
            default: send_op(REQ_ARRAY);
        endcase
    endtask

    // Stimulus, end of run and verdict.
    initial
    begin : stimulus
        logic [63:0] int_edges [8];
        int          random_start;
        int          codes_seen;

        int_edges = '{64'h0000_0000_0000_007F, 64'hFFFF_FFFF_FFFF_FF7F,
                      64'h0000_0000_0000_7FFF, 64'hFFFF_FFFF_FFFF_7FFF,
                      64'h0000_0000_7FFF_FFFF, 64'hFFFF_FFFF_7FFF_FFFF,
                      64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000};
        rst_n = 1'b0;
        token_valid = 1'b0;
        token = '0;
        result_ready = 1'b0;
        idling = 1'b1;
        stall_left = 0;
        cycles = 0;
        requests_sent = 0;
        shadow_depth = 0;
        deepest = 0;
        foreach (sent_by_code[i])
            sent_by_code[i] = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Scalars and the edges of each integer form.
        send_op(REQ_START);
        send_op(REQ_NULL);
        send_req(REQ_BOOL, '0, '0, 1'b1, '0, '0);
        send_req(REQ_BOOL, '0, '0, 1'b0, '0, '0);
        foreach (int_edges[i])
            send_req(REQ_INT, int_edges[i], '0, 1'b0, '0, '0);

        // A pop with nothing open, then a key outside any object whose bytes still pass.
        send_op(REQ_POP);
        send_text(REQ_KEY, 32'd3);

        // A key on top of an array, then keys and strings at the length boundaries.
        send_op(REQ_ARRAY);
        send_text(REQ_KEY, 32'd0);
        send_op(REQ_OBJECT);
        send_text(REQ_KEY, 32'd127);
        send_text(REQ_STRING, 32'd128);
        send_text(REQ_STRING, 32'd32767);
        send_text(REQ_STRING, 32'd32768);
        send_text(REQ_STRING, 32'hFFFF_FFFF);
        send_req(REQ_TEXT, '0, '0, 1'b0, '0, 8'h00);
        send_req(REQ_TEXT, '1, '1, 1'b1, '1, 8'hFF);
        send_req(REQ_UUID, '1, 64'h0123_4567_89AB_CDEF, 1'b0, '0, '0);
        send_req(REQ_TIME, 64'h8000_0000_0000_0001, '0, 1'b0, '0, '0);

        // A finish closes both open levels; a second finish has nothing to close.
        send_op(REQ_FINISH);
        send_op(REQ_FINISH);
        for (int c = 13; c < 16; c++)
            send_op(4'(c));

        // Nesting to the full depth, one level too many, a pop, and a finish of the remaining levels.
        send_op(REQ_START);
        for (int i = 0; i <= STACK_DEPTH; i++)
            send_op(i % 2 == 0 ? REQ_OBJECT : REQ_ARRAY);
        send_op(REQ_POP);
        send_op(REQ_FINISH);

        // Random documents with random content, mixed with noise requests.
        random_start = requests_sent;
        send_op(REQ_START);
        while (requests_sent - random_start < RANDOM_REQUESTS)
        begin
            if (requests_sent - random_start >= RANDOM_REQUESTS - 20)
                idling = 1'b0;
            else if ($urandom_range(0, 15) == 0)
                idling = ($urandom_range(0, 3) != 0);

            case ($urandom_range(0, 99)) inside
                [0:7]:   send_req(4'($urandom_range(0, 15)), rnd64(), rnd64(),
                                  1'($urandom_range(0, 1)), $urandom,
                                  8'($urandom_range(0, 255)));
                [8:9]:
                begin
                    while (shadow_depth < STACK_DEPTH)
                        send_op($urandom_range(0, 1) ? REQ_OBJECT : REQ_ARRAY);
                    send_op($urandom_range(0, 1) ? REQ_OBJECT : REQ_ARRAY);
                end
                [10:14]:
                begin
                    send_op(REQ_FINISH);
                    send_op(REQ_START);
                end
                [15:34]:
                begin
                    if (shadow_depth > 0)
                        send_op(REQ_POP);
                    else
                        send_value();
                end
                default:
                begin
                    if (shadow_depth > 0 && shadow_kind[shadow_depth - 1])
                        send_text(REQ_KEY, rnd_len());
                    send_value();
                end
            endcase
        end
        send_op(REQ_FINISH);
        token_valid <= 1'b0;

        // Let the last acceptance reach the checker, then drain what is still due.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        codes_seen = 0;
        foreach (sent_by_code[i])
            if (sent_by_code[i] != 0)
                codes_seen++;
        $display("Sent %0d requests using %0d of 16 request codes; nesting reached %0d of %0d.",
                 requests_sent, codes_seen, deepest, STACK_DEPTH);
        $display("Compared %0d results against the predicted byte stream.", checked);
        if (error_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
